// ===== design/mcbm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcbm_pkg
// Types, codes and constants shared by the multicart bank mapper modules.
// ----------------------------------------------------------------------------
package mcbm_pkg;

  localparam logic [15:0] SELECT_ADDR     = 16'h5100;
  localparam logic [7:0]  BANK3_RESET     = 8'h0C;
  localparam logic [7:0]  INNER_FULL_MASK = 8'h0F;
  localparam int          QUEUE_DEPTH     = 2;
  localparam int          DIV_STEPS       = 8;

  localparam logic ACT_SELECT = 1'b0;
  localparam logic ACT_PRG    = 1'b1;

  localparam logic [1:0] REG_PRG_BANKS   = 2'd0;
  localparam logic [1:0] REG_CHR_BANKS   = 2'd1;
  localparam logic [1:0] REG_FOUR_SCREEN = 2'd2;

  localparam logic [1:0] BANK_CHR    = 2'd0;
  localparam logic [1:0] BANK_OUTER  = 2'd1;
  localparam logic [1:0] BANK_MIRROR = 2'd2;
  localparam logic [1:0] BANK_MODE   = 2'd3;

  localparam logic [1:0] MODE_32K_A     = 2'd0;
  localparam logic [1:0] MODE_32K_B     = 2'd1;
  localparam logic [1:0] MODE_16K_OUTER = 2'd2;
  localparam logic [1:0] MODE_16K_INNER = 2'd3;

  typedef struct packed {
    logic        action;
    logic [15:0] address;
    logic [7:0]  data;
  } in_word_t;

  typedef struct packed {
    logic       prg_is_32k;
    logic [6:0] prg_bank_low;
    logic [6:0] prg_bank_high;
    logic [1:0] chr_bank;
    logic       mirror_valid;
    logic [1:0] mirroring;
  } out_word_t;

  typedef struct packed {
    logic [6:0] prg_16k_banks;
    logic [4:0] chr_8k_banks;
    logic       four_screen_mode;
  } cfg_t;

  // One mapping job handed from the front to the back.
  typedef struct packed {
    logic       prg_is_32k;
    logic [7:0] dividend_low;
    logic [7:0] dividend_high;
    logic [6:0] divisor;
    logic [1:0] chr_bank;
    logic       mirror_valid;
    logic [1:0] mirroring;
  } job_t;

endpackage : mcbm_pkg
`default_nettype wire

// ===== design/mcbm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcbm_front
// Accepts CPU writes, updates the bank registers and builds a mapping job.
// ----------------------------------------------------------------------------
module mcbm_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire mcbm_pkg::in_word_t in_data,
  input  wire mcbm_pkg::cfg_t    cfg,
  input  wire logic              q_full,
  output      logic              q_push,
  output      mcbm_pkg::job_t    q_job
);
  import mcbm_pkg::*;

  logic [7:0] bank_r   [4];
  logic [7:0] bank_nxt [4];
  logic [1:0] sel_r;
  logic [1:0] sel_nxt;
  logic       accept;
  logic [1:0] mode;
  logic [7:0] outer;
  logic [3:0] inner;
  logic [6:0] p;
  logic [6:0] p32;
  logic [1:0] chr_raw;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  always_comb begin
    bank_nxt = bank_r;
    sel_nxt  = sel_r;
    if (accept) begin
      if (in_data.action == ACT_SELECT) begin
        if (in_data.address == SELECT_ADDR) begin
          sel_nxt = in_data.data[1:0];
        end
      end else begin
        bank_nxt[sel_r] = in_data.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r[BANK_CHR]    <= 8'd0;
      bank_r[BANK_OUTER]  <= 8'd0;
      bank_r[BANK_MIRROR] <= 8'd0;
      bank_r[BANK_MODE]   <= BANK3_RESET;
      sel_r               <= 2'd0;
    end else begin
      bank_r <= bank_nxt;
      sel_r  <= sel_nxt;
    end
  end

  always_comb begin
    mode    = bank_nxt[BANK_MODE][3:2];
    outer   = {bank_nxt[BANK_OUTER][6:0], 1'b0};
    inner   = bank_nxt[BANK_MODE][3:0];
    p       = (cfg.prg_16k_banks == 7'd0) ? 7'd1 : cfg.prg_16k_banks;
    p32     = (p[6:1] == 6'd0) ? 7'd1 : {1'b0, p[6:1]};
    chr_raw = bank_nxt[BANK_CHR][1:0];

    q_job = '0;
    unique case (mode)
      MODE_32K_A, MODE_32K_B: begin
        q_job.prg_is_32k    = 1'b1;
        q_job.dividend_low  = outer | {5'd0, inner[3:1]};
        q_job.dividend_high = 8'd0;
        q_job.divisor       = p32;
      end
      MODE_16K_OUTER: begin
        q_job.dividend_low  = outer;
        q_job.dividend_high = outer | {1'b0, 7'(p - 7'd1)};
        q_job.divisor       = p;
      end
      default: begin
        q_job.dividend_low  = outer | {4'd0, inner};
        q_job.dividend_high = outer | INNER_FULL_MASK;
        q_job.divisor       = p;
      end
    endcase

    // The raw character bank is below four, so the remainder is a short case list.
    priority if (cfg.chr_8k_banks <= 5'd1) begin
      q_job.chr_bank = 2'd0;
    end else if (cfg.chr_8k_banks == 5'd2) begin
      q_job.chr_bank = {1'b0, chr_raw[0]};
    end else if (cfg.chr_8k_banks == 5'd3) begin
      q_job.chr_bank = (chr_raw == 2'd3) ? 2'd0 : chr_raw;
    end else begin
      q_job.chr_bank = chr_raw;
    end

    q_job.mirror_valid = !cfg.four_screen_mode;
    q_job.mirroring    = cfg.four_screen_mode ? 2'd0 : bank_nxt[BANK_MIRROR][1:0];
  end

endmodule : mcbm_front
`default_nettype wire

// ===== design/mcbm_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcbm_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module mcbm_queue #(
  parameter int DEPTH = mcbm_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mcbm_pkg::job_t push_job,
  output      logic           full,
  input  wire logic           pop,
  output      mcbm_pkg::job_t pop_job,
  output      logic           not_empty
);
  import mcbm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_job   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule : mcbm_queue
`default_nettype wire

// ===== design/mcbm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcbm_back
// Reduces the program bank numbers with a bit-serial restoring remainder
// and holds the finished mapping word in the output register.
// ----------------------------------------------------------------------------
module mcbm_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_not_empty,
  input  wire mcbm_pkg::job_t  q_job,
  output      logic            q_pop,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      mcbm_pkg::out_word_t out_data
);
  import mcbm_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  job_t              job_r;
  job_t              job_nxt;
  logic [7:0]        dvd_lo_r;
  logic [7:0]        dvd_lo_nxt;
  logic [7:0]        dvd_hi_r;
  logic [7:0]        dvd_hi_nxt;
  logic [6:0]        rem_lo_r;
  logic [6:0]        rem_lo_nxt;
  logic [6:0]        rem_hi_r;
  logic [6:0]        rem_hi_nxt;
  out_word_t         out_r;
  out_word_t         out_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [7:0]        trial_lo;
  logic [7:0]        trial_hi;
  logic [7:0]        div_ext;
  logic              load_out;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign q_pop     = (state_r == ST_IDLE) && q_not_empty;
  assign load_out  = (state_r == ST_HOLD) && (!out_valid_r || out_ready);

  always_comb begin
    div_ext  = {1'b0, job_r.divisor};
    trial_lo = {rem_lo_r, dvd_lo_r[7]};
    trial_hi = {rem_hi_r, dvd_hi_r[7]};

    state_nxt     = state_r;
    step_nxt      = step_r;
    job_nxt       = job_r;
    dvd_lo_nxt    = dvd_lo_r;
    dvd_hi_nxt    = dvd_hi_r;
    rem_lo_nxt    = rem_lo_r;
    rem_hi_nxt    = rem_hi_r;
    out_nxt       = out_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          job_nxt    = q_job;
          dvd_lo_nxt = q_job.dividend_low;
          dvd_hi_nxt = q_job.dividend_high;
          rem_lo_nxt = 7'd0;
          rem_hi_nxt = 7'd0;
          step_nxt   = '0;
          state_nxt  = ST_RUN;
        end
      end
      ST_RUN: begin
        rem_lo_nxt = (trial_lo >= div_ext) ? 7'(trial_lo - div_ext) : trial_lo[6:0];
        rem_hi_nxt = (trial_hi >= div_ext) ? 7'(trial_hi - div_ext) : trial_hi[6:0];
        dvd_lo_nxt = {dvd_lo_r[6:0], 1'b0};
        dvd_hi_nxt = {dvd_hi_r[6:0], 1'b0};
        step_nxt   = STEP_W'(step_r + 1'b1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (load_out) begin
          out_nxt.prg_is_32k    = job_r.prg_is_32k;
          out_nxt.prg_bank_low  = rem_lo_r;
          out_nxt.prg_bank_high = rem_hi_r;
          out_nxt.chr_bank      = job_r.chr_bank;
          out_nxt.mirror_valid  = job_r.mirror_valid;
          out_nxt.mirroring     = job_r.mirroring;
          out_valid_nxt         = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    job_r    <= job_nxt;
    dvd_lo_r <= dvd_lo_nxt;
    dvd_hi_r <= dvd_hi_nxt;
    rem_lo_r <= rem_lo_nxt;
    rem_hi_r <= rem_hi_nxt;
    out_r    <= out_nxt;
  end

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (job_r.divisor != 7'd0))
    else $error("remainder unit runs with a zero divisor");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> (rem_lo_r < job_r.divisor) && (rem_hi_r < job_r.divisor))
    else $error("remainder not below divisor");

  a_32k_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_r.prg_is_32k |-> (out_r.prg_bank_high == 7'd0))
    else $error("upper bank not zero in 32K mode");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_RUN) && (step_r == '0))
    else $error("job popped without starting the remainder unit");

endmodule : mcbm_back
`default_nettype wire

// ===== design/multicart_bank_mapper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multicart_bank_mapper
// Path: an accepted word goes through the queue to the remainder unit, which
// runs its eight bit-serial steps, then puts the mapping word on out_data.
// Flow: the remainder unit takes one job at a time; a short queue lets the
// input keep taking words while the remainder unit or the output stalls.
// Reset: synchronous, active low; bank registers return to 0, 0, 0, 0x0C,
// the select to 0 and the configuration to 2 banks, 1 bank, no four-screen.
// ----------------------------------------------------------------------------
module multicart_bank_mapper #(
  parameter int QUEUE_DEPTH = mcbm_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire mcbm_pkg::in_word_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      mcbm_pkg::out_word_t out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output      logic [31:0]         prdata,
  output      logic                pready
);
  import mcbm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic cfg_we;
  job_t push_job;
  job_t pop_job;
  logic push;
  logic pop;
  logic full;
  logic not_empty;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (paddr[3:2])
        REG_PRG_BANKS:   cfg_nxt.prg_16k_banks    = pwdata[6:0];
        REG_CHR_BANKS:   cfg_nxt.chr_8k_banks     = pwdata[4:0];
        REG_FOUR_SCREEN: cfg_nxt.four_screen_mode = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PRG_BANKS:   prdata = {25'd0, cfg_r.prg_16k_banks};
      REG_CHR_BANKS:   prdata = {27'd0, cfg_r.chr_8k_banks};
      REG_FOUR_SCREEN: prdata = {31'd0, cfg_r.four_screen_mode};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prg_16k_banks    <= 7'd2;
      cfg_r.chr_8k_banks     <= 5'd1;
      cfg_r.four_screen_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mcbm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (full),
    .q_push   (push),
    .q_job    (push_job)
  );

  mcbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .pop       (pop),
    .pop_job   (pop_job),
    .not_empty (not_empty)
  );

  mcbm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (not_empty),
    .q_job       (pop_job),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule : multicart_bank_mapper
`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for the multicart bank mapper
// Streams CPU select and program writes into the mapper under random flow
// control, steps through several ROM layouts over the APB port, and compares
// every mapping word with a cycle-free model of the bank registers.
// ----------------------------------------------------------------------------
module testbench;
  import mcbm_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         LIMIT      = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  multicart_bank_mapper dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  in_word_t  cpu_writes[$];
  out_word_t mappings[$];

  logic [7:0] bank_reg[4];
  logic [1:0] sel_idx;
  logic [6:0] cfg_prg;
  logic [4:0] cfg_chr;
  logic       cfg_four;

  int   idle_rate = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  logic in_taken = 1'b0;
  int   errors = 0;
  int   cycle_count = 0;

  task automatic store_write(in_word_t w);
    if (w.action == ACT_SELECT) begin
      if (w.address == SELECT_ADDR) begin
        sel_idx = w.data[1:0];
      end
    end else begin
      bank_reg[sel_idx] = w.data;
    end
  endtask

  function automatic out_word_t current_mapping();
    out_word_t m;
    logic [1:0] mode;
    logic [7:0] outer;
    logic [7:0] inner;
    int unsigned p;
    int unsigned p32;
    m = '0;
    mode = bank_reg[BANK_MODE][3:2];
    outer = {bank_reg[BANK_OUTER][6:0], 1'b0};
    inner = {4'b0, bank_reg[BANK_MODE][3:0]};
    p = (cfg_prg == 0) ? 1 : cfg_prg;
    p32 = (p / 2 == 0) ? 1 : p / 2;
    if (mode <= MODE_32K_B) begin
      m.prg_is_32k = 1'b1;
      m.prg_bank_low = 7'((outer | (inner >> 1)) % p32);
    end else if (mode == MODE_16K_OUTER) begin
      m.prg_bank_low = 7'(outer % p);
      m.prg_bank_high = 7'((outer | (p - 1)) % p);
    end else begin
      m.prg_bank_low = 7'((outer | inner) % p);
      m.prg_bank_high = 7'((outer | INNER_FULL_MASK) % p);
    end
    if (cfg_chr != 0) begin
      m.chr_bank = 2'(bank_reg[BANK_CHR][1:0] % cfg_chr);
    end
    m.mirror_valid = !cfg_four;
    if (!cfg_four) begin
      m.mirroring = bank_reg[BANK_MIRROR][1:0];
    end
    return m;
  endfunction

  task automatic add_word(logic act, logic [15:0] addr, logic [7:0] data);
    in_word_t w;
    w.action = act;
    w.address = addr;
    w.data = data;
    cpu_writes.push_back(w);
  endtask

  task automatic add_random(int count);
    int made;
    made = 0;
    while (made < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          add_word(ACT_SELECT, SELECT_ADDR, 8'($urandom));
          add_word(ACT_PRG, 16'($urandom), 8'($urandom));
          made += 2;
        end
        7, 8: begin
          add_word(ACT_PRG, 16'($urandom), 8'($urandom));
          made += 1;
        end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            add_word(ACT_SELECT, SELECT_ADDR ^ (16'd1 << $urandom_range(0, 15)),
                     8'($urandom));
          end else begin
            add_word(ACT_SELECT, 16'($urandom), 8'($urandom));
          end
          made += 1;
        end
      endcase
    end
  endtask

  task automatic drain();
    while (cpu_writes.size() != 0 || in_valid || mappings.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    int keep;
    keep = (idx == REG_PRG_BANKS) ? 7 : (idx == REG_CHR_BANKS) ? 5 : 1;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= (idx == REG_UNUSED) ? $urandom : (($urandom << keep) | val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PRG_BANKS: cfg_prg = val[6:0];
      REG_CHR_BANKS: cfg_chr = val[4:0];
      REG_FOUR_SCREEN: cfg_four = val[0];
      default: ;
    endcase
  endtask

  task automatic set_layout(int unsigned prg, int unsigned chr, int unsigned four);
    write_reg(REG_PRG_BANKS, prg);
    write_reg(REG_CHR_BANKS, chr);
    write_reg(REG_FOUR_SCREEN, four);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (idle_rate != 0 && $urandom_range(1, 16) <= idle_rate) begin
        in_valid <= 1'b0;
        in_gap <= $urandom_range(0, 14);
      end else if (cpu_writes.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= cpu_writes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 150;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (idle_rate != 0 && $urandom_range(1, 16) <= idle_rate) begin
      out_gap <= $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      store_write(in_data);
      mappings.push_back(current_mapping());
    end
    if (rst_n && out_valid && out_ready) begin
      if (mappings.size() == 0) begin
        $error("mapping word with none expected: %h", out_data);
        errors++;
      end else begin
        want = mappings.pop_front();
        if (out_data.prg_is_32k !== want.prg_is_32k) begin
          $error("prg_is_32k: expected %0d, got %0d", want.prg_is_32k, out_data.prg_is_32k);
          errors++;
        end
        if (out_data.prg_bank_low !== want.prg_bank_low) begin
          $error("prg_bank_low: expected %0d, got %0d",
                 want.prg_bank_low, out_data.prg_bank_low);
          errors++;
        end
        if (out_data.prg_bank_high !== want.prg_bank_high) begin
          $error("prg_bank_high: expected %0d, got %0d",
                 want.prg_bank_high, out_data.prg_bank_high);
          errors++;
        end
        if (out_data.chr_bank !== want.chr_bank) begin
          $error("chr_bank: expected %0d, got %0d", want.chr_bank, out_data.chr_bank);
          errors++;
        end
        if (out_data.mirror_valid !== want.mirror_valid) begin
          $error("mirror_valid: expected %0d, got %0d",
                 want.mirror_valid, out_data.mirror_valid);
          errors++;
        end
        if (out_data.mirroring !== want.mirroring) begin
          $error("mirroring: expected %0d, got %0d", want.mirroring, out_data.mirroring);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    bank_reg[BANK_CHR] = 8'h00;
    bank_reg[BANK_OUTER] = 8'h00;
    bank_reg[BANK_MIRROR] = 8'h00;
    bank_reg[BANK_MODE] = BANK3_RESET;
    sel_idx = 2'd0;
    cfg_prg = 7'd2;
    cfg_chr = 5'd1;
    cfg_four = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Every bank mode, the register select, and selects that miss the port.
    idle_rate = 4;
    add_word(ACT_PRG, 16'h0000, 8'h00);
    add_word(ACT_SELECT, SELECT_ADDR, 8'hFF);
    add_word(ACT_PRG, 16'hFFFF, 8'h00);
    add_word(ACT_PRG, 16'h8000, 8'h04);
    add_word(ACT_PRG, 16'h8000, 8'h08);
    add_word(ACT_PRG, 16'hC000, 8'h0C);
    add_word(ACT_PRG, 16'hFFFF, 8'hFF);
    add_word(ACT_SELECT, 16'h5101, 8'h00);
    add_word(ACT_SELECT, 16'h50FF, 8'h01);
    add_word(ACT_SELECT, 16'hFFFF, 8'h02);
    add_word(ACT_PRG, 16'h8000, 8'h0B);
    add_word(ACT_SELECT, SELECT_ADDR, 8'h01);
    add_word(ACT_PRG, 16'h8000, 8'hFF);
    add_word(ACT_SELECT, SELECT_ADDR, 8'hFE);
    add_word(ACT_PRG, 16'h8000, 8'h03);
    add_word(ACT_PRG, 16'h8000, 8'h01);
    add_word(ACT_SELECT, SELECT_ADDR, 8'h00);
    add_word(ACT_PRG, 16'h8000, 8'hFF);
    add_word(ACT_SELECT, 16'h0000, 8'hFF);
    add_word(ACT_PRG, SELECT_ADDR, 8'h02);
    add_random(200);
    drain();

    // Largest layout with four-screen; the output is held off for a long
    // stretch so the mapper fills and stops taking words.
    set_layout(127, 31, 1);
    add_word(ACT_SELECT, SELECT_ADDR, 8'h03);
    add_word(ACT_PRG, 16'h8000, 8'h0E);
    add_word(ACT_SELECT, SELECT_ADDR, 8'h01);
    add_word(ACT_PRG, 16'h8000, 8'h7F);
    hold_go = 1'b1;
    add_random(250);
    drain();

    // Single program bank and character RAM, with no idling at all.
    idle_rate = 0;
    set_layout(1, 0, 0);
    add_random(200);
    drain();

    // Zero program banks and a write to a register that does not exist.
    idle_rate = 6;
    set_layout(0, 3, 1);
    write_reg(REG_UNUSED, 0);
    add_random(200);
    drain();

    repeat (4) begin
      idle_rate = $urandom_range(2, 10);
      set_layout($urandom_range(1, 127), $urandom_range(0, 31), $urandom_range(0, 1));
      add_random(220);
      drain();
    end

    idle_rate = 0;
    set_layout(127, 1, 0);
    add_random(230);
    drain();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
